// File: sv/wett_pkg.sv
// Shared types and constants for the windowed energy threshold trigger.
// No dependencies; every other file imports this package.
package wett_pkg;

  localparam int CHAN_W     = 4;
  localparam int ENERGY_W   = 28;
  localparam int CNT_W      = 5;
  localparam int WLEN_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX     = '1;
  localparam logic [CNT_W-1:0]    CNT_MAX        = '1;
  localparam logic [WLEN_W-1:0]   WLEN_RESET     = 7'd10;
  localparam logic [CHAN_W-1:0]   MASKED_CHANNEL = 4'd15;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH,
    CFG_MASK_ENABLE
  } cfg_reg_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy_sum;
    logic                hit;
    logic                first_hit;
    logic [CNT_W-1:0]    channels_hit;
  } out_word_t;

endpackage

// File: sv/wett_if.sv
// Handshake channel interfaces for the windowed energy threshold trigger.
// Depends on wett_pkg.
interface wett_in_if import wett_pkg::*; #(parameter int SAMPLE_BITS = 12) ();
  logic                          valid;
  logic                          ready;
  logic [CHAN_W-1:0]             channel;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          first_of_waveform;
  logic                          new_event;
  logic [ENERGY_W-1:0]           threshold_sum;

  modport source (output valid, channel, sample, first_of_waveform, new_event,
                  threshold_sum, input ready);
  modport sink   (input valid, channel, sample, first_of_waveform, new_event,
                  threshold_sum, output ready);
endinterface

interface wett_out_if import wett_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ENERGY_W-1:0] energy_sum;
  logic                hit;
  logic                first_hit;
  logic [CNT_W-1:0]    channels_hit;

  modport source (output valid, energy_sum, hit, first_hit, channels_hit, input ready);
  modport sink   (input valid, energy_sum, hit, first_hit, channels_hit, output ready);
endinterface

interface wett_cfg_if import wett_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/windowed_energy_threshold_trigger_unit.sv
// Sliding-window energy detector over interleaved channels, with per-event hit count.
// Depends on wett_pkg, wett_if and wett_out_fifo.
//
// One sample word is accepted per clock while in_ch.ready is high. Its result is
// formed in the registered result stage and pushed into a four-word output queue whose
// head drives the output. Samples live in one ring memory (2**CH_W x 2**clog2(WINDOW_MAX)
// words) and the running window sums in a second per-channel memory. Each word reads
// both, updates the sum with the square of the new sample minus the square of the one
// leaving the window, and writes it back, with a bypass for the same channel on
// consecutive words. A write of window_length starts a recompute pass over all
// channels that reads the ring once per window slot, W slots per channel, W being the
// window length clamped to 1..WINDOW_MAX, then writes each channel's sum back.
// in_ch.ready is low during the write cycle and the pass, and while the output queue
// has no room for another word. Configuration writes are always taken.
module windowed_energy_threshold_trigger_unit import wett_pkg::*; #(
  parameter int CHANNELS    = 16,
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  wett_cfg_if.sink   cfg_ch,
  wett_in_if.sink    in_ch,
  wett_out_if.source out_ch
);

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W   = $clog2(WINDOW_MAX);
  localparam int POS_W   = $clog2(WINDOW_MAX + 2);
  localparam int WIN_W   = $clog2(WINDOW_MAX + 1);
  localparam int SQ_W    = 2 * SAMPLE_BITS;
  localparam int SUM_W   = 2 * SAMPLE_BITS - 1 + PTR_W;
  localparam int CMP_W   = (SUM_W > ENERGY_W) ? SUM_W : ENERGY_W;
  localparam int CLAMP_W = (WIN_W > WLEN_W) ? WIN_W : WLEN_W;
  localparam int RING_AW = CH_W + PTR_W;
  localparam int POS_MAX = WINDOW_MAX + 1;

  typedef enum logic [1:0] {
    PS_IDLE,
    PS_SUM,
    PS_DRAIN,
    PS_WB
  } pass_state_t;

  function automatic logic [WIN_W-1:0] clamp_win(input logic [WLEN_W-1:0] v);
    logic [CLAMP_W-1:0] e;
    e = CLAMP_W'(v);
    if (e == '0) begin
      e = CLAMP_W'(1);
    end else if (e > CLAMP_W'(WINDOW_MAX)) begin
      e = CLAMP_W'(WINDOW_MAX);
    end
    return WIN_W'(e);
  endfunction

  function automatic logic [SQ_W-1:0] square(input logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] mag;
    mag = s[SAMPLE_BITS-1] ? (~s + SAMPLE_BITS'(1)) : s;
    return SQ_W'(mag) * SQ_W'(mag);
  endfunction

  // memories
  logic [SAMPLE_BITS-1:0] ring_mem [2**RING_AW];
  logic [SUM_W-1:0]       sum_mem  [2**CH_W];
  logic [SAMPLE_BITS-1:0] ring_rd_r;
  logic [SUM_W-1:0]       sum_rd_r;

  // per-channel control
  logic [PTR_W-1:0] head_r [2**CH_W];
  logic [POS_W-1:0] pos_r  [2**CH_W];
  logic             seen_r [2**CH_W];

  // configuration
  logic [WIN_W-1:0] w_eff_r;
  logic             mask_r;
  logic             cfg_wr;
  logic             win_wr;

  // recompute pass
  pass_state_t      ps_r;
  logic [CH_W-1:0]  pass_ch_r;
  logic [WIN_W-1:0] k_r;
  logic [SUM_W-1:0] acc_r;
  logic             p_rd_v_r;
  logic             p_use_r;
  logic             pass_busy;

  // accept stage
  logic                   accept;
  logic                   ch_ok;
  logic [CH_W-1:0]        ch_idx;
  logic [CH_W-1:0]        rd_idx;
  logic [PTR_W-1:0]       head_sel;
  logic [POS_W-1:0]       pos_sel;
  logic [POS_W-1:0]       pos_eff;
  logic [POS_W-1:0]       pos_inc;
  logic [RING_AW-1:0]     ring_rd_addr;
  logic [SAMPLE_BITS-1:0] smp;

  // result stage
  logic                   b_valid_r;
  logic                   b_ch_ok_r;
  logic [CH_W-1:0]        b_ch_r;
  logic                   b_restart_r;
  logic                   b_newev_r;
  logic                   b_masked_r;
  logic                   b_drop_r;
  logic [POS_W-1:0]       b_pos_r;
  logic [ENERGY_W-1:0]    b_thr_r;
  logic [SQ_W-1:0]        b_sqnew_r;
  logic                   fwd_v_r;
  logic [CH_W-1:0]        fwd_ch_r;
  logic [SUM_W-1:0]       fwd_sum_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       cnt_base;
  logic [CNT_W-1:0]       cnt_nxt;
  logic [SQ_W-1:0]        sq_old;
  logic [SUM_W-1:0]       s_prev;
  logic [SUM_W-1:0]       s_new;
  logic [ENERGY_W-1:0]    energy_sat;
  logic [ENERGY_W-1:0]    energy;
  logic                   seen_eff;
  logic                   hit;
  logic                   first;
  logic                   sum_we;
  logic [CH_W-1:0]        sum_wa;
  logic [SUM_W-1:0]       sum_wd;
  out_word_t              res_word;
  logic [OUT_CNT_W-1:0]   fifo_count;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  assign win_wr       = cfg_wr && (cfg_ch.index == CFG_WINDOW_LENGTH);
  assign pass_busy    = (ps_r != PS_IDLE);

  assign in_ch.ready = !pass_busy && !win_wr
                       && (({1'b0, fifo_count} + (OUT_CNT_W + 1)'(b_valid_r))
                           < (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  assign ch_idx   = CH_W'(in_ch.channel);
  assign ch_ok    = int'(in_ch.channel) < CHANNELS;
  assign smp      = in_ch.sample;
  assign rd_idx   = pass_busy ? pass_ch_r : ch_idx;
  assign head_sel = head_r[rd_idx];
  assign pos_sel  = pos_r[rd_idx];
  assign pos_eff  = in_ch.first_of_waveform ? '0 : pos_sel;
  assign pos_inc  = (pos_eff == POS_W'(POS_MAX)) ? pos_eff : pos_eff + POS_W'(1);

  always_comb begin
    if (pass_busy) begin
      ring_rd_addr = {pass_ch_r, head_sel - PTR_W'(k_r)};
    end else begin
      ring_rd_addr = {ch_idx, head_sel - PTR_W'(w_eff_r)};
    end
  end

  always_ff @(posedge clk) begin
    ring_rd_r <= ring_mem[ring_rd_addr];
    if (accept && ch_ok) begin
      ring_mem[{ch_idx, head_sel}] <= smp;
    end
  end

  always_ff @(posedge clk) begin
    sum_rd_r <= sum_mem[ch_idx];
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= clamp_win(WLEN_RESET);
      mask_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_ch.index)
        CFG_WINDOW_LENGTH: w_eff_r <= clamp_win(cfg_ch.data[WLEN_W-1:0]);
        CFG_MASK_ENABLE:   mask_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2**CH_W; i++) begin
        head_r[i] <= '0;
        pos_r[i]  <= '0;
        seen_r[i] <= 1'b0;
      end
    end else begin
      if (accept && ch_ok) begin
        head_r[ch_idx] <= head_sel + PTR_W'(1);
        pos_r[ch_idx]  <= pos_inc;
      end
      if (b_valid_r && b_ch_ok_r) begin
        seen_r[b_ch_r] <= seen_eff || first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      fwd_v_r   <= 1'b0;
      cnt_r     <= '0;
    end else begin
      b_valid_r <= accept;
      fwd_v_r   <= b_valid_r && b_ch_ok_r;
      if (b_valid_r) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_ch_ok_r   <= ch_ok;
    b_ch_r      <= ch_idx;
    b_restart_r <= in_ch.first_of_waveform;
    b_newev_r   <= in_ch.new_event;
    b_masked_r  <= mask_r && (in_ch.channel == MASKED_CHANNEL);
    b_drop_r    <= POS_W'(w_eff_r) <= pos_eff;
    b_pos_r     <= pos_eff;
    b_thr_r     <= in_ch.threshold_sum;
    b_sqnew_r   <= square(smp);
    fwd_ch_r    <= b_ch_r;
    fwd_sum_r   <= s_new;
  end

  assign sq_old = square(ring_rd_r);

  always_comb begin
    if (b_pos_r == '0) begin
      s_prev = '0;
    end else if (fwd_v_r && (fwd_ch_r == b_ch_r)) begin
      s_prev = fwd_sum_r;
    end else begin
      s_prev = sum_rd_r;
    end
    s_new = s_prev + SUM_W'(b_sqnew_r) - (b_drop_r ? SUM_W'(sq_old) : '0);

    if (CMP_W'(s_prev) > CMP_W'(ENERGY_MAX)) begin
      energy_sat = ENERGY_MAX;
    end else begin
      energy_sat = ENERGY_W'(s_prev);
    end
    energy   = (b_ch_ok_r && (b_pos_r > POS_W'(w_eff_r))) ? energy_sat : '0;
    seen_eff = !b_restart_r && seen_r[b_ch_r];
    hit      = b_ch_ok_r && !b_masked_r && (energy > b_thr_r);
    first    = hit && !seen_eff;

    cnt_base = b_newev_r ? '0 : cnt_r;
    cnt_nxt  = (first && (cnt_base != CNT_MAX)) ? cnt_base + CNT_W'(1) : cnt_base;

    res_word.energy_sum   = energy;
    res_word.hit          = hit;
    res_word.first_hit    = first;
    res_word.channels_hit = cnt_nxt;
  end

  always_comb begin
    if (ps_r == PS_WB) begin
      sum_we = 1'b1;
      sum_wa = pass_ch_r;
      sum_wd = acc_r;
    end else begin
      sum_we = b_valid_r && b_ch_ok_r;
      sum_wa = b_ch_r;
      sum_wd = s_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r      <= PS_IDLE;
      pass_ch_r <= '0;
      k_r       <= '0;
      acc_r     <= '0;
      p_rd_v_r  <= 1'b0;
      p_use_r   <= 1'b0;
    end else if (win_wr) begin
      ps_r      <= PS_SUM;
      pass_ch_r <= '0;
      k_r       <= WIN_W'(1);
      acc_r     <= '0;
      p_rd_v_r  <= 1'b0;
      p_use_r   <= 1'b0;
    end else begin
      p_rd_v_r <= (ps_r == PS_SUM);
      p_use_r  <= POS_W'(k_r) <= pos_sel;
      if (p_rd_v_r && p_use_r) begin
        acc_r <= acc_r + SUM_W'(sq_old);
      end
      case (ps_r)
        PS_SUM: begin
          k_r <= k_r + WIN_W'(1);
          if (k_r == w_eff_r) begin
            ps_r <= PS_DRAIN;
          end
        end
        PS_DRAIN: begin
          ps_r <= PS_WB;
        end
        PS_WB: begin
          acc_r <= '0;
          k_r   <= WIN_W'(1);
          if (pass_ch_r == CH_W'(CHANNELS - 1)) begin
            ps_r <= PS_IDLE;
          end else begin
            pass_ch_r <= pass_ch_r + CH_W'(1);
            ps_r      <= PS_SUM;
          end
        end
        default: begin
          ps_r <= PS_IDLE;
        end
      endcase
    end
  end

  wett_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (b_valid_r),
    .push_word (res_word),
    .count     (fifo_count),
    .out_ch    (out_ch)
  );

endmodule

// File: sv/wett_out_fifo.sv
// Result word queue in front of the output channel.
// Depends on wett_pkg and wett_out_if.
module wett_out_fifo import wett_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  out_word_t            push_word,
  output logic [OUT_CNT_W-1:0] count,
  wett_out_if.source           out_ch
);

  out_word_t              mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_r;
  logic [OUT_PTR_W-1:0]   rd_ptr_r;
  logic [OUT_CNT_W-1:0]   count_r;
  logic [OUT_CNT_W-1:0]   count_nxt;
  logic                   pop;
  out_word_t              head_word;

  assign pop       = out_ch.valid && out_ch.ready;
  assign head_word = mem_r[rd_ptr_r];
  assign count     = count_r;

  assign out_ch.valid        = (count_r != '0);
  assign out_ch.energy_sum   = head_word.energy_sum;
  assign out_ch.hit          = head_word.hit;
  assign out_ch.first_hit    = head_word.first_hit;
  assign out_ch.channels_hit = head_word.channels_hit;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + OUT_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OUT_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

// File: sv/wett_checker.sv
// Port-level checks for the windowed energy threshold trigger, bound to the top level.
// Depends on wett_pkg and windowed_energy_threshold_trigger_unit.
module wett_checker import wett_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [ENERGY_W-1:0]  energy_sum,
  input logic                 hit,
  input logic                 first_hit,
  input logic [CNT_W-1:0]     channels_hit
);

  logic [3:0] outst_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outst_r <= '0;
    end else begin
      outst_r <= outst_r + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(energy_sum) && $stable(hit)
      && $stable(first_hit) && $stable(channels_hit))
    else $error("stalled result word changed");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> outst_r != 4'd0)
    else $error("result word without an accepted sample word");

  a_window_write_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index == CFG_WINDOW_LENGTH) |=> !in_ready)
    else $error("sample word taken during window recompute");

  a_first_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_hit |-> hit && (energy_sum != '0) && (channels_hit != '0))
    else $error("first hit without hit, energy or count");

endmodule

bind windowed_energy_threshold_trigger_unit wett_checker u_wett_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .cfg_valid    (cfg_ch.valid),
  .cfg_ready    (cfg_ch.ready),
  .cfg_index    (cfg_ch.index),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .energy_sum   (out_ch.energy_sum),
  .hit          (out_ch.hit),
  .first_hit    (out_ch.first_hit),
  .channels_hit (out_ch.channels_hit)
);
